// ===== src/pthtab_pkg.sv =====
// Shared types, codes and sizing constants of the pointer tracking hash table.
package pthtab_pkg;

  localparam int TABLE_BITS = 12;
  localparam int TABLE_SIZE = 1 << TABLE_BITS;
  localparam int KEY_W      = 32;
  localparam int IDX_W      = 12;

  localparam logic [KEY_W-1:0] GOLDEN = 32'h9E37_79B9;

  typedef logic [TABLE_BITS-1:0] slot_t;
  typedef logic [KEY_W-1:0]      word_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam slot_t SLOT_ONE = slot_t'(1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_MISS     = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_ZERO_KEY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HOME,
    ST_PROBE,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

// ===== src/pointer_tracking_hash_table_top.sv =====
// Open-addressed pointer tracking table with a one-slot-per-cycle probe sequencer.
// Flow to out_tvalid: a zero key or unknown request goes straight to the result; insert and find
//   pass hash, home read and then one probe per slot (single read port). A remove that hits then reads
//   the slots behind it up to the empty one that ends its run, and hashes and re-places each entry moved back.
// Throughput: one request at a time; the next beat is taken once the result is queued.
// Reset: synchronous, active low; a clearing pass then empties every key slot, in_tready low.
module pointer_tracking_hash_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // key [31:0], entry_size [63:32], caller_addr [95:64]
  input  logic [1:0]  in_tuser,   // req_type [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // found_size [31:0], found_caller [63:32], slot_index [75:64]
  output logic [1:0]  out_tuser   // status [1:0]
);

  // Key, size and caller stores; one write and one registered read per cycle each.
  pthtab_pkg::word_t key_mem    [pthtab_pkg::TABLE_SIZE];
  pthtab_pkg::word_t size_mem   [pthtab_pkg::TABLE_SIZE];
  pthtab_pkg::word_t caller_mem [pthtab_pkg::TABLE_SIZE];

  pthtab_pkg::word_t key_rd_r, size_rd_r, caller_rd_r;

  pthtab_pkg::slot_t rd_addr, wr_addr;
  logic              key_we, data_we;
  pthtab_pkg::word_t key_wr;

  pthtab_pkg::state_t state_r, state_nxt;
  pthtab_pkg::req_t   req_r, req_nxt;
  logic               reins_r, reins_nxt;      // probe is moving an entry during a remove
  pthtab_pkg::word_t  wkey_r, wkey_nxt;
  pthtab_pkg::word_t  wsize_r, wsize_nxt;
  pthtab_pkg::word_t  wcaller_r, wcaller_nxt;
  pthtab_pkg::word_t  prod_r, prod_nxt;
  pthtab_pkg::slot_t  probe_r, probe_nxt;
  pthtab_pkg::slot_t  cnt_r, cnt_nxt;          // probes done in this search
  pthtab_pkg::slot_t  nslot_r, nslot_nxt;      // slot examined after the removed one
  pthtab_pkg::slot_t  scnt_r, scnt_nxt;        // distance of nslot from the removed slot
  pthtab_pkg::slot_t  clr_r, clr_nxt;

  pthtab_pkg::status_t res_status_r, res_status_nxt;
  pthtab_pkg::word_t   res_size_r, res_size_nxt;
  pthtab_pkg::word_t   res_caller_r, res_caller_nxt;
  pthtab_pkg::slot_t   res_idx_r, res_idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  pthtab_pkg::status_t out_status_r, out_status_nxt;
  pthtab_pkg::word_t   out_size_r, out_size_nxt;
  pthtab_pkg::word_t   out_caller_r, out_caller_nxt;
  pthtab_pkg::idx_t    out_idx_r, out_idx_nxt;

  logic              in_fire, out_free;
  logic              hit_match, hit_empty, probe_last, shift_last, placing;
  pthtab_pkg::slot_t home;
  pthtab_pkg::word_t in_key;

  assign in_key     = in_tdata[31:0];
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign hit_match  = (key_rd_r == wkey_r);
  assign hit_empty  = (key_rd_r == '0);
  assign probe_last = &cnt_r;
  assign shift_last = &scnt_r;
  assign placing    = (req_r == pthtab_pkg::REQ_INSERT) || reins_r;
  assign home       = prod_r[pthtab_pkg::KEY_W-1 -: pthtab_pkg::TABLE_BITS];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pthtab_pkg::ST_CLEAR: begin
        if (&clr_r) state_nxt = pthtab_pkg::ST_IDLE;
      end
      pthtab_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_key == '0 || pthtab_pkg::req_t'(in_tuser) == pthtab_pkg::REQ_NONE) begin
            state_nxt = pthtab_pkg::ST_DONE;
          end else begin
            state_nxt = pthtab_pkg::ST_HASH;
          end
        end
      end
      pthtab_pkg::ST_HASH: state_nxt = pthtab_pkg::ST_HOME;
      pthtab_pkg::ST_HOME: state_nxt = pthtab_pkg::ST_PROBE;
      pthtab_pkg::ST_PROBE: begin
        if (placing) begin
          if (hit_empty || hit_match || probe_last) begin
            if (reins_r && !shift_last) state_nxt = pthtab_pkg::ST_SHIFT;
            else                        state_nxt = pthtab_pkg::ST_DONE;
          end
        end else if (hit_match) begin
          if (req_r == pthtab_pkg::REQ_REMOVE) state_nxt = pthtab_pkg::ST_SHIFT;
          else                                 state_nxt = pthtab_pkg::ST_DONE;
        end else if (hit_empty || probe_last) begin
          state_nxt = pthtab_pkg::ST_DONE;
        end
      end
      pthtab_pkg::ST_SHIFT: begin
        if (hit_empty) state_nxt = pthtab_pkg::ST_DONE;
        else           state_nxt = pthtab_pkg::ST_HASH;
      end
      pthtab_pkg::ST_DONE: begin
        if (out_free) state_nxt = pthtab_pkg::ST_IDLE;
      end
      default: state_nxt = pthtab_pkg::ST_CLEAR;
    endcase
  end

  // Datapath, store control and result register.
  always_comb begin
    req_nxt        = req_r;
    reins_nxt      = reins_r;
    wkey_nxt       = wkey_r;
    wsize_nxt      = wsize_r;
    wcaller_nxt    = wcaller_r;
    prod_nxt       = prod_r;
    probe_nxt      = probe_r;
    cnt_nxt        = cnt_r;
    nslot_nxt      = nslot_r;
    scnt_nxt       = scnt_r;
    clr_nxt        = clr_r;
    res_status_nxt = res_status_r;
    res_size_nxt   = res_size_r;
    res_caller_nxt = res_caller_r;
    res_idx_nxt    = res_idx_r;
    rd_addr        = probe_r;
    wr_addr        = probe_r;
    key_we         = 1'b0;
    data_we        = 1'b0;
    key_wr         = wkey_r;

    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_size_nxt   = out_size_r;
    out_caller_nxt = out_caller_r;
    out_idx_nxt    = out_idx_r;

    unique case (state_r)
      pthtab_pkg::ST_CLEAR: begin
        // Sweep the key store: every slot empty.
        wr_addr = clr_r;
        key_we  = 1'b1;
        key_wr  = '0;
        clr_nxt = clr_r + pthtab_pkg::SLOT_ONE;
      end
      pthtab_pkg::ST_IDLE: begin
        if (in_fire) begin
          req_nxt        = pthtab_pkg::req_t'(in_tuser);
          reins_nxt      = 1'b0;
          wkey_nxt       = in_key;
          wsize_nxt      = in_tdata[63:32];
          wcaller_nxt    = in_tdata[95:64];
          res_size_nxt   = '0;
          res_caller_nxt = '0;
          res_idx_nxt    = '0;
          res_status_nxt = (in_key == '0) ? pthtab_pkg::STAT_ZERO_KEY : pthtab_pkg::STAT_MISS;
        end
      end
      pthtab_pkg::ST_HASH: begin
        prod_nxt = {2'b00, wkey_r[pthtab_pkg::KEY_W-1:2]} * pthtab_pkg::GOLDEN;
      end
      pthtab_pkg::ST_HOME: begin
        probe_nxt = home;
        cnt_nxt   = '0;
        rd_addr   = home;
      end
      pthtab_pkg::ST_PROBE: begin
        // Advance one slot each probe; the state logic ends the search on a hit, an empty slot or the last probe.
        probe_nxt = probe_r + pthtab_pkg::SLOT_ONE;
        cnt_nxt   = cnt_r + pthtab_pkg::SLOT_ONE;
        rd_addr   = probe_r + pthtab_pkg::SLOT_ONE;
        if (placing) begin
          if (hit_empty || hit_match) begin
            key_we  = 1'b1;
            data_we = 1'b1;
            if (!reins_r) begin
              res_status_nxt = pthtab_pkg::STAT_OK;
              res_idx_nxt    = probe_r;
            end
          end else if (probe_last && !reins_r) begin
            res_status_nxt = pthtab_pkg::STAT_FULL;
          end
          if (reins_r && (hit_empty || hit_match || probe_last)) begin
            nslot_nxt = nslot_r + pthtab_pkg::SLOT_ONE;
            scnt_nxt  = scnt_r + pthtab_pkg::SLOT_ONE;
            rd_addr   = nslot_r + pthtab_pkg::SLOT_ONE;
          end
        end else if (hit_match) begin
          res_status_nxt = pthtab_pkg::STAT_OK;
          res_idx_nxt    = probe_r;
          if (req_r == pthtab_pkg::REQ_FIND) begin
            res_size_nxt   = size_rd_r;
            res_caller_nxt = caller_rd_r;
          end else begin
            // Drop the key, then walk the following run.
            key_we    = 1'b1;
            key_wr    = '0;
            nslot_nxt = probe_r + pthtab_pkg::SLOT_ONE;
            scnt_nxt  = pthtab_pkg::SLOT_ONE;
          end
        end
      end
      pthtab_pkg::ST_SHIFT: begin
        if (!hit_empty) begin
          // Lift the entry out and place it again from its home slot.
          wkey_nxt    = key_rd_r;
          wsize_nxt   = size_rd_r;
          wcaller_nxt = caller_rd_r;
          reins_nxt   = 1'b1;
          wr_addr     = nslot_r;
          key_we      = 1'b1;
          key_wr      = '0;
        end
      end
      pthtab_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_size_nxt   = res_size_r;
          out_caller_nxt = res_caller_r;
          out_idx_nxt    = pthtab_pkg::idx_t'(res_idx_r);
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == pthtab_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0000, out_idx_r, out_caller_r, out_size_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pthtab_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    reins_r      <= reins_nxt;
    wkey_r       <= wkey_nxt;
    wsize_r      <= wsize_nxt;
    wcaller_r    <= wcaller_nxt;
    prod_r       <= prod_nxt;
    probe_r      <= probe_nxt;
    cnt_r        <= cnt_nxt;
    nslot_r      <= nslot_nxt;
    scnt_r       <= scnt_nxt;
    res_status_r <= res_status_nxt;
    res_size_r   <= res_size_nxt;
    res_caller_r <= res_caller_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_size_r   <= out_size_nxt;
    out_caller_r <= out_caller_nxt;
    out_idx_r    <= out_idx_nxt;
  end

  // Stores: a read of the slot being written returns the new value.
  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_addr] <= key_wr;
    if (key_we && wr_addr == rd_addr) key_rd_r <= key_wr;
    else                              key_rd_r <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      size_mem[wr_addr]   <= wsize_r;
      caller_mem[wr_addr] <= wcaller_r;
    end
    if (data_we && wr_addr == rd_addr) begin
      size_rd_r   <= wsize_r;
      caller_rd_r <= wcaller_r;
    end else begin
      size_rd_r   <= size_mem[rd_addr];
      caller_rd_r <= caller_mem[rd_addr];
    end
  end

endmodule

// ===== src/pthtab_chk.sv =====
// Port-level checker for the pointer tracking hash table, bound to the top level.
module pthtab_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [95:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // One request at a time: an accepted beat closes the input side.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or dropped");

  a_zero_key_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == pthtab_pkg::STAT_ZERO_KEY |-> out_tdata == '0)
    else $error("zero key result carries data");

  a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == pthtab_pkg::STAT_MISS |-> out_tdata == '0)
    else $error("miss result carries data");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == pthtab_pkg::STAT_FULL |-> out_tdata == '0)
    else $error("full result carries data");

endmodule

bind pointer_tracking_hash_table_top pthtab_chk u_pthtab_chk (.*);

// ===== dv/pthtab_checker.sv =====
// Reply checker for the pointer tracking table: mirrors the table and compares every reply.
module pthtab_checker
  import pthtab_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,   // key [31:0], entry_size [63:32], caller_addr [95:64]
  input  logic [1:0]  in_tuser,   // req_type [1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,  // found_size [31:0], found_caller [63:32], slot_index [75:64]
  input  logic [1:0]  out_tuser,  // status [1:0]
  output int          fail_count,
  output int          replies_owed
);

  typedef struct {
    status_t status;
    word_t   size;
    word_t   caller;
    idx_t    slot;
  } reply_t;

  word_t  mirror_key    [TABLE_SIZE];
  word_t  mirror_size   [TABLE_SIZE];
  word_t  mirror_caller [TABLE_SIZE];
  reply_t replies_due   [$];

  function automatic slot_t bucket_of(word_t k);
    word_t mix;
    mix = {2'b00, k[KEY_W-1:2]} * GOLDEN;
    return mix[KEY_W-1 -: TABLE_BITS];
  endfunction

  // Walk from the home bucket; take the first empty slot or the key's own slot.
  function automatic bit store_entry(word_t k, word_t sz, word_t cl, output slot_t where);
    slot_t s;
    int    i;
    s = bucket_of(k);
    where = '0;
    for (i = 0; i < TABLE_SIZE; i++) begin
      if (mirror_key[s] == '0 || mirror_key[s] == k) begin
        mirror_key[s]    = k;
        mirror_size[s]   = sz;
        mirror_caller[s] = cl;
        where = s;
        return 1'b1;
      end
      s = s + SLOT_ONE;
    end
    return 1'b0;
  endfunction

  function automatic bit seek_key(word_t k, output slot_t where);
    slot_t s;
    int    i;
    s = bucket_of(k);
    where = '0;
    for (i = 0; i < TABLE_SIZE; i++) begin
      if (mirror_key[s] == k) begin
        where = s;
        return 1'b1;
      end
      if (mirror_key[s] == '0) return 1'b0;
      s = s + SLOT_ONE;
    end
    return 1'b0;
  endfunction

  function automatic reply_t serve_request(req_t kind, word_t k, word_t sz, word_t cl);
    reply_t r;
    slot_t  s, n, spare;
    word_t  mk, ms, mc;
    bit     placed;
    int     i;
    r.status = STAT_MISS;
    r.size   = '0;
    r.caller = '0;
    r.slot   = '0;
    if (k == '0) begin
      r.status = STAT_ZERO_KEY;
    end else begin
      case (kind)
        REQ_INSERT: begin
          if (store_entry(k, sz, cl, s)) begin
            r.status = STAT_OK;
            r.slot   = idx_t'(s);
          end else begin
            r.status = STAT_FULL;
          end
        end
        REQ_FIND: begin
          if (seek_key(k, s)) begin
            r.status = STAT_OK;
            r.size   = mirror_size[s];
            r.caller = mirror_caller[s];
            r.slot   = idx_t'(s);
          end
        end
        REQ_REMOVE: begin
          if (seek_key(k, s)) begin
            r.status = STAT_OK;
            r.slot   = idx_t'(s);
            mirror_key[s] = '0;
            // Pull out and re-place every entry of the run behind the hole.
            n = s;
            for (i = 1; i < TABLE_SIZE; i++) begin
              n = n + SLOT_ONE;
              if (mirror_key[n] == '0) break;
              mk = mirror_key[n];
              ms = mirror_size[n];
              mc = mirror_caller[n];
              mirror_key[n] = '0;
              placed = store_entry(mk, ms, mc, spare);
            end
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want, got;
    int     bad;
    bad = 0;
    if (!rst_n) begin
      foreach (mirror_key[j]) mirror_key[j] = '0;
      replies_due.delete();
      fail_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser);
        got.size   = out_tdata[31:0];
        got.caller = out_tdata[63:32];
        got.slot   = out_tdata[75:64];
        if (replies_due.size() == 0) begin
          $display("%0t: expected no reply, got status %0d size %h caller %h slot %0d",
                   $time, out_tuser, got.size, got.caller, got.slot);
          bad = 1;
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status || got.size !== want.size ||
              got.caller !== want.caller || got.slot !== want.slot) begin
            $display("%0t: expected status %s size %h caller %h slot %0d", $time,
                     want.status.name(), want.size, want.caller, want.slot);
            $display("%0t:   actual status %0d size %h caller %h slot %0d", $time,
                     out_tuser, got.size, got.caller, got.slot);
            bad = 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        replies_due.push_back(serve_request(req_t'(in_tuser), in_tdata[31:0],
                                            in_tdata[63:32], in_tdata[95:64]));
      fail_count <= fail_count + bad;
    end
    replies_owed <= replies_due.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the pointer tracking table bench: clock, reset, request stimulus and verdict.
module testbench;
  import pthtab_pkg::*;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;   // key [31:0], entry_size [63:32], caller_addr [95:64]
  logic [1:0]  in_tuser   = '0;   // req_type [1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;         // found_size [31:0], found_caller [63:32], slot_index [75:64]
  logic [1:0]  out_tuser;         // status [1:0]
  int          fail_count;
  int          replies_owed;

  // High while both sides run without idle cycles.
  bit          steady = 1'b0;
  // Every key that may still sit in the table before the fill phase.
  word_t       key_pool [$];

  always #6 clk = ~clk;

  pointer_tracking_hash_table_top DUT (.*);

  pthtab_checker reply_check (.*);

  // Reply side: tready drops at random with about 8 percent chance, never during the steady stretch.
  always @(posedge clk) out_tready <= steady || ($urandom_range(99) >= 8);

  // Offer one request beat; idle randomly first, then hold until the table takes it.
  // Leave tvalid high afterwards so back-to-back beats never toggle it within one step.
  task automatic offer(input req_t kind, input word_t k, input word_t sz, input word_t cl);
    while (!steady && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cl, sz, k};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop tvalid and hold until every reply owed has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (replies_owed != 0);
  endtask

  initial begin
    word_t wrap_key, mix, k, b;
    word_t fill_keys [$];
    req_t  kind;
    int    n, pick, i;

    // Hunt a key whose home bucket is the last one, so its run wraps to bucket zero.
    wrap_key = '0;
    mix      = '0;
    while (mix[KEY_W-1 -: TABLE_BITS] != slot_t'(TABLE_SIZE - 1)) begin
      wrap_key = wrap_key + 32'd4;
      mix      = {2'b00, wrap_key[KEY_W-1:2]} * GOLDEN;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero key on every request kind, the all-ones key and field values.
    offer(REQ_INSERT, '0, '1, '1);
    offer(REQ_FIND,   '0, '0, '0);
    offer(REQ_REMOVE, '0, '1, '1);
    offer(REQ_NONE,   '0, '0, '0);
    offer(REQ_FIND,   '1, '0, '0);      // absent on an empty table
    offer(REQ_REMOVE, '1, '0, '0);
    offer(REQ_INSERT, '1, '1, '1);
    offer(REQ_FIND,   '1, '0, '0);
    offer(REQ_INSERT, '1, '0, '0);      // update in place
    offer(REQ_FIND,   '1, '1, '1);
    offer(REQ_NONE,   '1, '1, '1);      // unknown request leaves the entry alone
    offer(REQ_FIND,   '1, '0, '0);
    // Four keys that share the last bucket: the run wraps past the end.
    for (i = 0; i < 4; i++) begin
      offer(REQ_INSERT, wrap_key | word_t'(i), $urandom, $urandom);
      key_pool.push_back(wrap_key | word_t'(i));
    end
    offer(REQ_FIND,   wrap_key | 32'd3, '0, '0);
    offer(REQ_REMOVE, wrap_key, '0, '0); // pulls the wrapped entries back
    offer(REQ_FIND,   wrap_key | 32'd3, '0, '0);
    offer(REQ_FIND,   wrap_key | 32'd1, '0, '0);
    offer(REQ_REMOVE, '1, '0, '0);
    offer(REQ_FIND,   '1, '0, '0);
    key_pool.push_back('1);

    // Random: a small pool of keys, some sharing a bucket, so most requests hit.
    for (i = 0; i < 32; i++) begin
      b = $urandom;
      b[1:0] = 2'b00;
      if (b == '0) b = 32'd4;
      key_pool.push_back(b);
      if ($urandom_range(1)) begin
        key_pool.push_back(b | 32'd1);
        key_pool.push_back(b | 32'd2);
      end
    end
    for (n = 0; n < 1500; n++) begin
      steady = (n >= 500 && n < 800);
      if (n == 900) settle();
      pick = $urandom_range(99);
      if (pick < 40)      kind = REQ_INSERT;
      else if (pick < 70) kind = REQ_FIND;
      else if (pick < 95) kind = REQ_REMOVE;
      else                kind = REQ_NONE;
      pick = $urandom_range(99);
      if (pick < 3) begin
        k = '0;
      end else if (pick < 8) begin
        k = $urandom;   // almost surely absent
        if (kind == REQ_INSERT) key_pool.push_back(k);
      end else begin
        k = key_pool[$urandom_range(key_pool.size() - 1)];
      end
      offer(kind, k, $urandom, $urandom);
    end
    steady = 1'b0;

    // Empty the table, then fill every bucket with keys that spread evenly.
    foreach (key_pool[j]) offer(REQ_REMOVE, key_pool[j], '0, '0);
    settle();
    for (i = 1; i <= TABLE_SIZE; i++) begin
      k = (word_t'(i) << 2) | word_t'($urandom_range(3));
      fill_keys.push_back(k);
      offer(REQ_INSERT, k, $urandom, $urandom);
    end
    offer(REQ_INSERT, word_t'(TABLE_SIZE + 1) << 2, $urandom, $urandom);  // table full
    offer(REQ_INSERT, fill_keys[7], $urandom, $urandom);                // update when full
    offer(REQ_FIND,   fill_keys[7], '0, '0);
    offer(REQ_FIND,   word_t'(TABLE_SIZE + 2) << 2, '0, '0);            // scans every bucket
    offer(REQ_INSERT, '0, $urandom, $urandom);
    offer(REQ_NONE,   fill_keys[3], '0, '0);
    offer(REQ_REMOVE, fill_keys[100], '0, '0);                          // long pull-back
    offer(REQ_FIND,   fill_keys[101], '0, '0);
    offer(REQ_FIND,   fill_keys[100], '0, '0);
    offer(REQ_INSERT, word_t'(TABLE_SIZE + 1) << 2, $urandom, $urandom);
    offer(REQ_REMOVE, fill_keys[TABLE_SIZE - 1], '0, '0);
    offer(REQ_FIND,   fill_keys[0], '0, '0);

    // Drain, then give a stray reply time to show up.
    settle();
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: fails the run after a time far beyond the slowest correct run.
  initial begin
    #120_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
src/pthtab_pkg.sv
src/pointer_tracking_hash_table_top.sv
src/pthtab_chk.sv
dv/pthtab_checker.sv
dv/testbench.sv
